/* rtl/dwf_pkg.sv */
// ----------------------------------------------------------------------------
// dwf_pkg
// Shared types, constants and the control program of the deviation
// weighted fusion block.
// ----------------------------------------------------------------------------
`default_nettype none

package dwf_pkg;

    localparam int RISK_W = 16;
    localparam int STAT_W = 2;
    localparam int PAIR_W = 17;
    localparam int QUO_W  = 16;
    localparam int QCNT_W = $clog2(QUO_W);
    localparam int STEP_W = 5;

    // Set positions whose values are combined into the pair.
    localparam int PAIR_FIRST  = 3;
    localparam int PAIR_SECOND = 4;

    // Initial min and max of the deviation, 1000.0 and -1.0 in Q8.8.
    localparam int LO_SCALE = 256000;
    localparam int HI_SCALE = -256;

    localparam logic signed [RISK_W-1:0] VALID_FLOOR   = -16'sd256;
    localparam logic signed [RISK_W-1:0] NO_VALID_RISK = -16'sd256;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_VALID    = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_WEIGHT = 2'd2;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_INIT,
        OP_READ,
        OP_DEV,
        OP_MINMAX,
        OP_PASS2,
        OP_WEIGHT,
        OP_WPROD,
        OP_ACCUM,
        OP_SETDIV_W,
        OP_SETDIV_M,
        OP_DIVSTEP,
        OP_FIN_DIV,
        OP_FIN_NOVAL,
        OP_FIN_ZERO,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_FALSE,
        C_TRUE,
        C_CLOSED,
        C_CNT_ZERO,
        C_IDX_END,
        C_NO_SPREAD,
        C_DEN_ZERO,
        C_DIV_MORE,
        C_OUT_FREE
    } cond_t;

    // When cond holds the sequencer goes to target; otherwise it stays on
    // the step if hold is set and moves to the next step if not.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        step_t target;
    } uword_t;

    localparam step_t S_LOAD  = 5'd0;
    localparam step_t S_INIT  = 5'd1;
    localparam step_t S_RD1   = 5'd2;
    localparam step_t S_DEV   = 5'd3;
    localparam step_t S_MM    = 5'd4;
    localparam step_t S_CHK   = 5'd5;
    localparam step_t S_RD2   = 5'd6;
    localparam step_t S_WGT   = 5'd7;
    localparam step_t S_WPROD = 5'd8;
    localparam step_t S_ACC   = 5'd9;
    localparam step_t S_DCHK  = 5'd10;
    localparam step_t S_DIV   = 5'd11;
    localparam step_t S_FIN   = 5'd12;
    localparam step_t S_MEAN  = 5'd13;
    localparam step_t S_NOVAL = 5'd14;
    localparam step_t S_ZERO  = 5'd15;
    localparam step_t S_EMIT  = 5'd16;

    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        unique case (step)
            S_LOAD:  w = '{OP_LOAD,      C_CLOSED,    1'b1, S_INIT};
            S_INIT:  w = '{OP_INIT,      C_CNT_ZERO,  1'b0, S_NOVAL};
            S_RD1:   w = '{OP_READ,      C_IDX_END,   1'b0, S_CHK};
            S_DEV:   w = '{OP_DEV,       C_FALSE,     1'b0, S_LOAD};
            S_MM:    w = '{OP_MINMAX,    C_TRUE,      1'b0, S_RD1};
            S_CHK:   w = '{OP_PASS2,     C_NO_SPREAD, 1'b0, S_MEAN};
            S_RD2:   w = '{OP_READ,      C_IDX_END,   1'b0, S_DCHK};
            S_WGT:   w = '{OP_WEIGHT,    C_FALSE,     1'b0, S_LOAD};
            S_WPROD: w = '{OP_WPROD,     C_FALSE,     1'b0, S_LOAD};
            S_ACC:   w = '{OP_ACCUM,     C_TRUE,      1'b0, S_RD2};
            S_DCHK:  w = '{OP_SETDIV_W,  C_DEN_ZERO,  1'b0, S_ZERO};
            S_DIV:   w = '{OP_DIVSTEP,   C_DIV_MORE,  1'b0, S_DIV};
            S_FIN:   w = '{OP_FIN_DIV,   C_TRUE,      1'b0, S_EMIT};
            S_MEAN:  w = '{OP_SETDIV_M,  C_TRUE,      1'b0, S_DIV};
            S_NOVAL: w = '{OP_FIN_NOVAL, C_TRUE,      1'b0, S_EMIT};
            S_ZERO:  w = '{OP_FIN_ZERO,  C_FALSE,     1'b0, S_LOAD};
            S_EMIT:  w = '{OP_EMIT,      C_OUT_FREE,  1'b1, S_LOAD};
            default: w = '{OP_LOAD,      C_TRUE,      1'b0, S_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/deviation_weighted_fusion.sv */
// ----------------------------------------------------------------------------
// deviation_weighted_fusion
// Fuses a set of signed Q8.8 risk values into one deviation weighted mean.
// ----------------------------------------------------------------------------
// Each input transaction carries one risk value and is taken in one cycle;
// a value with last set closes the set, and the block then runs its fusion
// program and accepts no input until the result is in the output register.
// When the stored values spread, the fusion makes two passes over the
// value store and then runs a radix-2 divider; when they spread but the
// weights sum to zero it makes both passes and skips the divider; when
// they do not spread it makes one pass and then runs the divider; and
// when the set held no valid value it goes straight to its result. The
// passes read one stored value at a time through a single registered
// memory port, and the divider retires one quotient bit per cycle. A result
// not yet taken holds the block only when the next set has closed and its result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module deviation_weighted_fusion
    import dwf_pkg::*;
#(
    parameter int MAX_VALUES = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [RISK_W-1:0] risk_value,
    input  wire logic                     last,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [RISK_W-1:0]      fused_risk,
    output logic [STAT_W-1:0]             status
);

    localparam int CNT_W  = $clog2(MAX_VALUES + 1);
    localparam int ADDR_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int SUM_W  = RISK_W + CNT_W;
    localparam int EXT_W  = 19 + CNT_W;
    localparam int DEN_W  = EXT_W + CNT_W;
    localparam int PROD_W = RISK_W + EXT_W;
    localparam int NUM_W  = PROD_W + CNT_W;
    localparam int DIV_W  = NUM_W + QUO_W;

    // Sequencer
    step_t  step_reg, step_next;
    uword_t uw;
    logic   cond_hit;

    // Set state
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        stored_reg, stored_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [PAIR_W-1:0] pair_reg, pair_next;

    // Fusion datapath
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic signed [RISK_W-1:0] rd_reg;
    logic signed [EXT_W-1:0]  d_reg, d_next;
    logic signed [EXT_W-1:0]  hi_reg, hi_next;
    logic signed [EXT_W-1:0]  lo_reg, lo_next;
    logic signed [EXT_W-1:0]  w_reg, w_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [DIV_W-1:0]         dsh_reg, dsh_next;
    logic [QUO_W-1:0]         q_reg, q_next;
    logic [QCNT_W-1:0]        qcnt_reg, qcnt_next;
    logic                     neg_reg, neg_next;
    logic signed [RISK_W-1:0] res_reg, res_next;
    logic [STAT_W-1:0]        stat_reg, stat_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [RISK_W-1:0] fused_risk_reg, fused_risk_next;
    logic [STAT_W-1:0]        status_reg, status_next;

    logic signed [RISK_W-1:0] store_mem [MAX_VALUES];

    logic                     in_fire;
    logic                     out_free;
    logic                     idx_end;
    logic                     in_range;
    logic                     is_valid;
    logic                     at_pair;
    logic                     at_second;
    logic signed [PAIR_W-1:0] pair_add;
    logic                     half_ok;
    logic signed [RISK_W-1:0] half_val;
    logic                     store_en;
    logic signed [RISK_W-1:0] store_val;
    logic signed [EXT_W-1:0]  cnt_ext;
    logic signed [EXT_W-1:0]  dev_comb;
    logic signed [NUM_W-1:0]  div_src;
    logic [DEN_W-1:0]         div_by;
    logic [NUM_W-1:0]         div_mag;

    assign uw        = ucode_rom(step_reg);
    assign in_ready  = (uw.op == OP_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign idx_end   = (idx_reg == stored_reg);

    assign out_valid  = out_valid_reg;
    assign fused_risk = fused_risk_reg;
    assign status     = status_reg;

    // Load path: valid values go to the sum and the store, except at the two
    // pair positions, whose halved sum is stored at the second one unless it is negative.
    assign in_range  = (pos_reg < CNT_W'(MAX_VALUES));
    assign is_valid  = (risk_value > VALID_FLOOR);
    assign at_pair   = (32'(pos_reg) == PAIR_FIRST) || (32'(pos_reg) == PAIR_SECOND);
    assign at_second = (32'(pos_reg) == PAIR_SECOND);
    assign pair_add  = (is_valid && at_pair) ? pair_reg + PAIR_W'(risk_value) : pair_reg;
    assign half_ok   = at_second && !pair_add[PAIR_W-1];
    assign half_val  = $signed(pair_add[PAIR_W-1:1]);
    assign store_en  = in_fire && in_range && ((is_valid && !at_pair) || half_ok);
    assign store_val = half_ok ? half_val : risk_value;

    // Deviations are scaled by the valid count so they stay exact integers.
    assign cnt_ext  = EXT_W'($signed({1'b0, cnt_reg}));
    assign dev_comb = cnt_ext * EXT_W'(rd_reg) - EXT_W'(sum_reg);

    assign div_src = (uw.op == OP_SETDIV_M) ? NUM_W'(sum_reg) : num_reg;
    assign div_by  = (uw.op == OP_SETDIV_M) ? DEN_W'(cnt_reg) : den_reg;
    assign div_mag = div_src[NUM_W-1] ? $unsigned(-div_src) : $unsigned(div_src);

    always_comb
    begin
        unique case (uw.cond)
            C_FALSE:     cond_hit = 1'b0;
            C_TRUE:      cond_hit = 1'b1;
            C_CLOSED:    cond_hit = in_fire && last;
            C_CNT_ZERO:  cond_hit = (cnt_reg == '0);
            C_IDX_END:   cond_hit = idx_end;
            C_NO_SPREAD: cond_hit = !(hi_reg > lo_reg);
            C_DEN_ZERO:  cond_hit = (den_reg == '0);
            C_DIV_MORE:  cond_hit = (qcnt_reg != '0);
            C_OUT_FREE:  cond_hit = out_free;
            default:     cond_hit = 1'b0;
        endcase

        if (cond_hit)
        begin
            step_next = uw.target;
        end
        else if (uw.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        stored_next     = stored_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        pair_next       = pair_reg;
        idx_next        = idx_reg;
        d_next          = d_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        w_next          = w_reg;
        prod_next       = prod_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        q_next          = q_reg;
        qcnt_next       = qcnt_reg;
        neg_next        = neg_reg;
        res_next        = res_reg;
        stat_next       = stat_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        fused_risk_next = fused_risk_reg;
        status_next     = status_reg;

        unique case (uw.op)
            OP_LOAD:
            begin
                if (in_fire && in_range)
                begin
                    pair_next = pair_add;
                    if (is_valid)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (store_en)
                    begin
                        sum_next    = sum_reg + SUM_W'(store_val);
                        stored_next = stored_reg + 1'b1;
                    end
                    pos_next = pos_reg + 1'b1;
                end
            end
            OP_INIT:
            begin
                lo_next  = cnt_ext * EXT_W'(LO_SCALE);
                hi_next  = cnt_ext * EXT_W'(HI_SCALE);
                idx_next = '0;
            end
            OP_READ:
            begin
                // The store read itself sits in the memory block below.
            end
            OP_DEV:
            begin
                d_next = dev_comb;
            end
            OP_MINMAX:
            begin
                if (d_reg > hi_reg)
                begin
                    hi_next = d_reg;
                end
                if (d_reg < lo_reg)
                begin
                    lo_next = d_reg;
                end
                idx_next = idx_reg + 1'b1;
            end
            OP_PASS2:
            begin
                idx_next = '0;
                num_next = '0;
                den_next = '0;
            end
            OP_WEIGHT:
            begin
                w_next = dev_comb - lo_reg;
            end
            OP_WPROD:
            begin
                den_next  = den_reg + DEN_W'($unsigned(w_reg));
                prod_next = PROD_W'(rd_reg) * PROD_W'(w_reg);
            end
            OP_ACCUM:
            begin
                num_next = num_reg + NUM_W'(prod_reg);
                idx_next = idx_reg + 1'b1;
            end
            OP_SETDIV_W,
            OP_SETDIV_M:
            begin
                neg_next  = div_src[NUM_W-1];
                rem_next  = DIV_W'(div_mag);
                dsh_next  = DIV_W'(div_by) << (QUO_W - 1);
                q_next    = '0;
                qcnt_next = QCNT_W'(QUO_W - 1);
            end
            OP_DIVSTEP:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[QUO_W-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                qcnt_next = qcnt_reg - 1'b1;
            end
            OP_FIN_DIV:
            begin
                res_next  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
                stat_next = ST_OK;
            end
            OP_FIN_NOVAL:
            begin
                res_next  = NO_VALID_RISK;
                stat_next = ST_NO_VALID;
            end
            OP_FIN_ZERO:
            begin
                res_next  = '0;
                stat_next = ST_ZERO_WEIGHT;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    fused_risk_next = res_reg;
                    status_next     = stat_reg;
                    pos_next        = '0;
                    stored_next     = '0;
                    cnt_next        = '0;
                    sum_next        = '0;
                    pair_next       = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_LOAD;
            pos_reg       <= '0;
            stored_reg    <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            pair_reg      <= '0;
            idx_reg       <= '0;
            qcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            stored_reg    <= stored_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            pair_reg      <= pair_next;
            idx_reg       <= idx_next;
            qcnt_reg      <= qcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg          <= d_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        w_reg          <= w_next;
        prod_reg       <= prod_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        dsh_reg        <= dsh_next;
        q_reg          <= q_next;
        neg_reg        <= neg_next;
        res_reg        <= res_next;
        stat_reg       <= stat_next;
        fused_risk_reg <= fused_risk_next;
        status_reg     <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            store_mem[stored_reg[ADDR_W-1:0]] <= store_val;
        end
        if ((uw.op == OP_READ) && !idx_end)
        begin
            rd_reg <= store_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    a_no_valid_risk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_VALID) |-> fused_risk == NO_VALID_RISK)
        else $error("no-valid result without the -1.0 risk value");

    a_zero_weight_risk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ZERO_WEIGHT) |-> fused_risk == '0)
        else $error("zero weight result with a nonzero risk value");

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= pos_reg)
        else $error("more stored values than set positions");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= CNT_W'(MAX_VALUES))
        else $error("set position beyond capacity");

endmodule

`default_nettype wire

/* verif/fusion_checker.sv */
// ----------------------------------------------------------------------------
// fusion_checker
// Watches both channels of the deviation weighted fusion block. It keeps
// its own copy of the set being loaded, computes the fused risk and status
// for every closing transaction, and compares each delivered result with
// the oldest one still due.
// ----------------------------------------------------------------------------
module fusion_checker
    import dwf_pkg::*;
#(
    parameter int MAX_VALUES = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_ready,
    input  wire logic signed [RISK_W-1:0] risk_value,
    input  wire logic                     last,
    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire logic signed [RISK_W-1:0] fused_risk,
    input  wire logic [STAT_W-1:0]        status,
    output int                            mismatches,
    output int                            awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [RISK_W-1:0] risk;
        logic [STAT_W-1:0]        stat;
    } fusion_t;

    fusion_t due_fusions[$];

    // Copy of the set that the block is loading.
    logic signed [RISK_W-1:0] held [MAX_VALUES];
    int held_n;
    int set_sum;
    int set_count;
    int set_pos;
    int pair_acc;

    int fail_count = 0;

    assign mismatches = fail_count;

    task automatic clear_set_copy();
        held_n    = 0;
        set_sum   = 0;
        set_count = 0;
        set_pos   = 0;
        pair_acc  = 0;
    endtask

    task automatic keep_value(input logic signed [RISK_W-1:0] v);
        if (held_n < MAX_VALUES)
        begin
            held[held_n] = v;
            held_n++;
        end
    endtask

    task automatic queue_fusion(input fusion_t f);
        due_fusions = {due_fusions, f};
    endtask

    // Deviations are scaled by the valid count so that min, max and the
    // weights stay exact integers.
    function automatic fusion_t fuse_set();
        longint  c;
        longint  s;
        longint  lo;
        longint  hi;
        longint  d;
        longint  w;
        longint  num;
        longint  den;
        longint  q;
        fusion_t r;
        c  = set_count;
        s  = set_sum;
        lo = LO_SCALE * c;
        hi = HI_SCALE * c;
        if (c == 0)
        begin
            r.risk = NO_VALID_RISK;
            r.stat = ST_NO_VALID;
            return r;
        end
        for (int i = 0; i < held_n; i++)
        begin
            d = c * longint'(held[i]) - s;
            if (d > hi)
                hi = d;
            if (d < lo)
                lo = d;
        end
        if (hi - lo > 0)
        begin
            num = 0;
            den = 0;
            for (int i = 0; i < held_n; i++)
            begin
                w   = c * longint'(held[i]) - s - lo;
                den += w;
                num += longint'(held[i]) * w;
            end
            if (den == 0)
            begin
                r.risk = '0;
                r.stat = ST_ZERO_WEIGHT;
                return r;
            end
            q = num / den;
        end
        else
        begin
            q = s / c;
        end
        r.risk = q[RISK_W-1:0];
        r.stat = ST_OK;
        return r;
    endfunction

    task automatic absorb_value(input logic signed [RISK_W-1:0] v, input logic closes);
        int half;
        if (set_pos < MAX_VALUES)
        begin
            if (v > VALID_FLOOR)
            begin
                if (set_pos == PAIR_FIRST || set_pos == PAIR_SECOND)
                begin
                    pair_acc += v;
                end
                else
                begin
                    set_sum += v;
                    keep_value(v);
                end
                set_count++;
            end
            // A negative pair contributes nothing to the sum or the store.
            if (set_pos == PAIR_SECOND && pair_acc >= 0)
            begin
                half = pair_acc >>> 1;
                set_sum += half;
                keep_value(RISK_W'(half));
            end
            set_pos++;
        end
        if (closes)
        begin
            queue_fusion(fuse_set());
            clear_set_copy();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        fusion_t oldest;
        if (!rst_n)
        begin
            clear_set_copy();
            due_fusions.delete();
            awaiting <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_fusions.size() == 0)
                begin
                    $error("result with none due: fused_risk %0d, status %0d",
                           fused_risk, status);
                    fail_count++;
                end
                else
                begin
                    oldest = due_fusions.pop_front();
                    if (fused_risk !== oldest.risk)
                    begin
                        $error("fused_risk: expected %0d, actual %0d",
                               oldest.risk, fused_risk);
                        fail_count++;
                    end
                    if (status !== oldest.stat)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.stat, status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                absorb_value(risk_value, last);
            awaiting <= due_fusions.size();
        end
    end

endmodule

/* verif/deviation_weighted_fusion_test.sv */
// ----------------------------------------------------------------------------
// deviation_weighted_fusion_test
// Drives sets of risk values into the fusion block with random gaps on the
// input and random stalls on the output, including one long output stall
// that backs the block up. A checker beside the block predicts and compares
// every result; this module builds the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module deviation_weighted_fusion_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dwf_pkg::*;

    localparam int ITEM_GOAL   = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF    = 400;
    localparam int HOLD_AT     = 25;
    localparam int DRAIN       = 100;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic signed [RISK_W-1:0] risk_value = '0;
    logic                     last       = 1'b0;
    logic                     out_ready  = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic signed [RISK_W-1:0] fused_risk;
    logic [STAT_W-1:0]        status;

    int   mismatches;
    int   awaiting;
    int   items_sent    = 0;
    int   results_taken = 0;
    int   cycles        = 0;
    logic burst         = 1'b0;
    int   set_values[$];

    deviation_weighted_fusion dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .risk_value (risk_value),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .fused_risk (fused_risk),
        .status     (status)
    );

    fusion_checker fusion_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .risk_value (risk_value),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .fused_risk (fused_risk),
        .status     (status),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[deviation_weighted_fusion] ERROR");
                $finish;
            end
        end
    end

    // Starts and returns at a falling edge; valid stays high between
    // back-to-back transactions.
    task automatic send_item(input logic signed [RISK_W-1:0] v, input logic closes);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        risk_value <= v;
        last       <= closes;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_set();
        for (int i = 0; i < set_values.size(); i++)
            send_item(RISK_W'(set_values[i]), i == set_values.size() - 1);
    endtask

    task automatic add_value(input int v);
        set_values = {set_values, v};
    endtask

    // Receiver: a random stall before each result, quiet stretches, and one
    // long hold-off so that the block fills and stops taking input.
    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (results_taken == HOLD_AT)
                stall = HOLD_OFF;
            else if ((results_taken % 64) >= 48)
                stall = 0;
            else
                stall = $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_taken++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int len;
        int mode;
        int base;
        int k;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_values = '{32767};
        send_set();
        set_values = '{-32768};
        send_set();
        set_values = '{-256, -255};
        send_set();
        // Pair of valid values with a negative sum, and an invalid value.
        set_values = '{10, -256, -255, -200, -100, 40};
        send_set();
        // The set closes on the first value of the pair.
        set_values = '{50, 60, 70, 80};
        send_set();
        // One value past capacity is dropped.
        set_values = '{32767, -255, 0, 300, 500, -32768, 1, 2, 3};
        send_set();
        set_values = '{128, 128, 128};
        send_set();

        while (items_sent < ITEM_GOAL)
        begin
            burst = ($urandom_range(0, 5) == 0);
            k     = $urandom_range(0, 19);
            len   = (k < 2) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            mode  = $urandom_range(0, 9);
            base  = $urandom_range(0, 2047) - 256;
            set_values.delete();
            repeat (len)
            begin
                k = $urandom_range(0, 9);
                if (mode == 0)
                    add_value(base);
                else if (mode == 1 || k == 0)
                    add_value(-int'($urandom_range(256, 32768)));
                else if (k < 3)
                    add_value(int'($urandom_range(0, 65535)));
                else
                    add_value(base + int'($urandom_range(0, 1023)) - 512);
            end
            send_set();
        end
        in_valid <= 1'b0;
        burst = 1'b0;

        while (awaiting != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("[deviation_weighted_fusion] OK");
        else
            $display("[deviation_weighted_fusion] ERROR");
        $finish;
    end

endmodule

/* deviation_weighted_fusion.f */
rtl/dwf_pkg.sv
rtl/deviation_weighted_fusion.sv
verif/fusion_checker.sv
verif/deviation_weighted_fusion_test.sv
